@@ design/tss_pkg.sv @@
// tss_pkg: shared types, constants and helpers of the trajectory segment sampler
// used by tss_dp and trajectory_segment_sampler_core; no dependencies
`default_nettype none

package tss_pkg;

  localparam int AXES           = 3;
  localparam int WRITABLE_TERMS = 8;

  localparam logic       REQ_WRITE = 1'b0;
  localparam logic       REQ_EVAL  = 1'b1;

  localparam logic [3:0] OP_IDLE  = 4'd0;
  localparam logic [3:0] OP_INIT  = 4'd1;
  localparam logic [3:0] OP_CLEAR = 4'd2;
  localparam logic [3:0] OP_MAG   = 4'd3;
  localparam logic [3:0] OP_LO    = 4'd4;
  localparam logic [3:0] OP_HI    = 4'd5;
  localparam logic [3:0] OP_SCL   = 4'd6;
  localparam logic [3:0] OP_ACC   = 4'd7;
  localparam logic [3:0] OP_RND   = 4'd8;

  typedef struct packed {
    logic              req_type;
    logic [5:0]        segment_index;
    logic [1:0]        axis_index;
    logic [2:0]        term_index;
    logic signed [47:0] coefficient_value;
    logic [23:0]       local_time;
  } tss_in_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_z;
    logic signed [47:0] vel_x;
    logic signed [47:0] vel_y;
    logic signed [47:0] vel_z;
    logic signed [47:0] acc_x;
    logic signed [47:0] acc_y;
    logic signed [47:0] acc_z;
    logic               saturated;
  } tss_out_t;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] weight;
    logic       coef_zero;
  } tss_ctrl_t;

  // derivative weight of the coefficient of t^(m+d), which becomes the t^m term after d derivatives
  function automatic logic [7:0] deriv_weight(input logic [4:0] m, input logic [1:0] d);
    logic [9:0] a;
    logic [9:0] b;
    logic [9:0] p;
    begin
      a = 10'(m) + 10'd1;
      b = 10'(m) + 10'd2;
      p = a * b;
      case (d)
        2'd0:    deriv_weight = 8'd1;
        2'd1:    deriv_weight = a[7:0];
        default: deriv_weight = p[7:0];
      endcase
    end
  endfunction

endpackage

`default_nettype wire

@@ design/tss_ram.sv @@
// tss_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module tss_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ design/tss_dp.sv @@
// tss_dp: shared fixed-point datapath (32x24 multiplier, scaler, accumulator, rounder)
// depends on tss_pkg
`default_nettype none

module tss_dp (
  input  wire logic               clk,
  input  wire tss_pkg::tss_ctrl_t ctrl,
  input  wire logic [23:0]        t,
  input  wire logic signed [47:0] coef,
  output logic signed [47:0]      res,
  output logic                    clip
);

  localparam logic [63:0] POS_LIM = {1'b0, {63{1'b1}}};
  localparam logic [63:0] NEG_LIM = {1'b1, {63{1'b0}}};
  localparam logic [47:0] POS48   = {1'b0, {47{1'b1}}};
  localparam logic [47:0] NEG48   = {1'b1, {47{1'b0}}};

  logic signed [63:0] acc_r;
  logic [63:0]        mag_r;
  logic               neg_r;
  logic [55:0]        plo_r;
  logic [55:0]        phi_r;
  logic signed [56:0] cw_r;
  logic [63:0]        mtm_r;
  logic [47:0]        rnd_r;
  logic               clip_r;

  logic [31:0]        mul_a;
  logic [55:0]        prod;
  logic signed [56:0] cw_prod;
  logic [56:0]        lo_rnd;
  logic [63:0]        sm;
  logic               hi_big;
  logic [63:0]        mtm_nxt;
  logic               sc_clip;
  logic signed [65:0] sum;
  logic               acc_ovf;
  logic signed [63:0] acc_nxt;
  logic [63:0]        acc_abs;
  logic [64:0]        rs;
  logic [48:0]        r;
  logic [47:0]        rnd_nxt;
  logic               rnd_clip;

  // shared multiplier: low or high half of the magnitude times time
  assign mul_a = (ctrl.op == tss_pkg::OP_HI) ? mag_r[63:32] : mag_r[31:0];
  assign prod  = 56'(mul_a) * 56'(t);

  assign cw_prod = 57'(coef) * 57'($signed({1'b0, ctrl.weight}));

  assign acc_abs = acc_r[63] ? (64'd0 - $unsigned(acc_r)) : $unsigned(acc_r);

  // product scaling back to q31.32 with saturation of the magnitude
  always_comb begin
    lo_rnd  = 57'(plo_r) + 57'(16'h8000);
    sm      = {phi_r[46:0], 16'd0} + 64'(lo_rnd[56:16]);
    hi_big  = |phi_r[55:47];
    mtm_nxt = sm;
    sc_clip = 1'b0;
    if (hi_big) begin
      mtm_nxt = neg_r ? NEG_LIM : POS_LIM;
      sc_clip = 1'b1;
    end else if (!neg_r && sm[63]) begin
      mtm_nxt = POS_LIM;
      sc_clip = 1'b1;
    end else if (neg_r && sm[63] && (|sm[62:0])) begin
      mtm_nxt = NEG_LIM;
      sc_clip = 1'b1;
    end
  end

  always_comb begin
    if (neg_r) begin
      sum = 66'(cw_r) - $signed({2'b00, mtm_r});
    end else begin
      sum = 66'(cw_r) + $signed({2'b00, mtm_r});
    end
    acc_ovf = !((sum[65:63] == 3'b000) || (sum[65:63] == 3'b111));
    if (acc_ovf) begin
      acc_nxt = sum[65] ? $signed(NEG_LIM) : $signed(POS_LIM);
    end else begin
      acc_nxt = sum[63:0];
    end
  end

  // final rounding to q31.16
  always_comb begin
    rs       = 65'(mag_r) + 65'(16'h8000);
    r        = rs[64:16];
    rnd_nxt  = r[47:0];
    rnd_clip = 1'b0;
    if (!neg_r && (r[48] || r[47])) begin
      rnd_nxt  = POS48;
      rnd_clip = 1'b1;
    end else if (neg_r && (r[48] || (r[47] && (|r[46:0])))) begin
      rnd_nxt  = NEG48;
      rnd_clip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      tss_pkg::OP_INIT: begin
        acc_r  <= '0;
        clip_r <= 1'b0;
      end
      tss_pkg::OP_CLEAR: begin
        acc_r <= '0;
      end
      tss_pkg::OP_MAG: begin
        mag_r <= acc_abs;
        neg_r <= acc_r[63];
      end
      tss_pkg::OP_LO: begin
        plo_r <= prod;
      end
      tss_pkg::OP_HI: begin
        phi_r <= prod;
        cw_r  <= ctrl.coef_zero ? '0 : cw_prod;
      end
      tss_pkg::OP_SCL: begin
        mtm_r  <= mtm_nxt;
        clip_r <= clip_r | sc_clip;
      end
      tss_pkg::OP_ACC: begin
        acc_r  <= acc_nxt;
        clip_r <= clip_r | acc_ovf;
      end
      tss_pkg::OP_RND: begin
        rnd_r  <= rnd_nxt;
        clip_r <= clip_r | rnd_clip;
      end
      default: begin
      end
    endcase
  end

  assign res  = $signed(neg_r ? (48'd0 - rnd_r) : rnd_r);
  assign clip = clip_r;

endmodule

`default_nettype wire

@@ design/trajectory_segment_sampler_core.sv @@
// trajectory_segment_sampler_core: top level, sequencer, coefficient store and result register
// depends on tss_pkg, tss_ram, tss_dp
//
// A write transaction (req_type 0) stores one signed q15.32 coefficient; writes
// to a segment, axis or term out of range are dropped. An evaluate transaction (req_type 1)
// returns position, velocity and acceleration of x, y and z in signed q31.16 with a flag for
// any clipping, or nothing when the segment is out of range. Evaluation runs Horner's scheme
// on one shared 32x24 multiplier: each step runs through magnitude, low and high half
// products, scaling and accumulate, and each of the nine axis/derivative results ends with
// magnitude, rounding and store; in_ready stays low while an evaluate occupies the block.
// The result register lets the next transaction be accepted while a result waits.
// Coefficients must be written before they are read.
`default_nettype none

module trajectory_segment_sampler_core #(
  parameter int SEGMENTS = 64,
  parameter int TERMS    = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tss_pkg::tss_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tss_pkg::tss_out_t      out_data
);

  localparam int SW    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int MW    = $clog2(TERMS);
  localparam int SXW   = (SW > 6) ? SW : 6;
  localparam int TXW   = (MW > 3) ? MW : 3;
  localparam int DEPTH = SEGMENTS * (4 << MW);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] T_MAG  = 4'd2;
  localparam logic [3:0] T_LO   = 4'd3;
  localparam logic [3:0] T_HI   = 4'd4;
  localparam logic [3:0] T_SCL  = 4'd5;
  localparam logic [3:0] T_ACC  = 4'd6;
  localparam logic [3:0] F_MAG  = 4'd7;
  localparam logic [3:0] F_RND  = 4'd8;
  localparam logic [3:0] F_STO  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]          state_r, state_nxt;
  logic [SW-1:0]       seg_r, seg_nxt;
  logic [23:0]         t_r, t_nxt;
  logic [1:0]          d_r, d_nxt;
  logic [1:0]          ax_r, ax_nxt;
  logic [MW-1:0]       m_r, m_nxt;
  logic signed [47:0]  res_r [9];
  logic                out_valid_r, out_valid_nxt;
  tss_pkg::tss_out_t   out_data_r;
  logic                out_load;

  logic                accept;
  logic                seg_ok;
  logic                eval_seg_ok;
  logic                ram_we;
  logic                ram_re;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [47:0]         ram_rdata;
  logic [SXW-1:0]      seg_w;
  logic [TXW-1:0]      term_w;
  logic [4:0]          termsum;
  logic [3:0]          slot;
  logic [1:0]          nd;
  logic                store;
  tss_pkg::tss_ctrl_t  ctrl;
  logic signed [47:0]  dp_res;
  logic                dp_clip;

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign seg_w       = SXW'(in_data.segment_index);
  assign term_w      = TXW'(in_data.term_index);
  assign seg_ok      = (32'(in_data.segment_index) < SEGMENTS);
  assign eval_seg_ok = seg_ok && (in_data.req_type == tss_pkg::REQ_EVAL);

  assign ram_we = accept && (in_data.req_type == tss_pkg::REQ_WRITE) && seg_ok &&
                  (32'(in_data.axis_index) < tss_pkg::AXES) &&
                  (32'(in_data.term_index) < TERMS);
  assign ram_waddr = AW'({seg_w[SW-1:0], in_data.axis_index, term_w[MW-1:0]});

  assign termsum   = 5'(m_r) + 5'(d_r);
  assign ram_re    = (state_r == T_MAG);
  assign ram_raddr = AW'({seg_r, ax_r, termsum[MW-1:0]});

  assign slot  = 4'({d_r, 1'b0}) + 4'(d_r) + 4'(ax_r);
  assign nd    = (ax_r == 2'd2) ? (d_r + 2'd1) : d_r;
  assign store = (state_r == F_STO);

  tss_ram #(
    .WIDTH (48),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_data.coefficient_value),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  tss_dp u_dp (
    .clk  (clk),
    .ctrl (ctrl),
    .t    (t_r),
    .coef ($signed(ram_rdata)),
    .res  (dp_res),
    .clip (dp_clip)
  );

  always_comb begin
    state_nxt      = state_r;
    seg_nxt        = seg_r;
    t_nxt          = t_r;
    d_nxt          = d_r;
    ax_nxt         = ax_r;
    m_nxt          = m_r;
    out_valid_nxt  = out_valid_r;
    out_load       = 1'b0;
    ctrl.op        = tss_pkg::OP_IDLE;
    ctrl.weight    = tss_pkg::deriv_weight(5'(m_r), d_r);
    ctrl.coef_zero = (termsum >= 5'(tss_pkg::WRITABLE_TERMS));

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept && eval_seg_ok) begin
          seg_nxt   = seg_w[SW-1:0];
          t_nxt     = in_data.local_time;
          d_nxt     = 2'd0;
          ax_nxt    = 2'd0;
          m_nxt     = MW'(TERMS - 1);
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        ctrl.op   = tss_pkg::OP_INIT;
        state_nxt = T_MAG;
      end
      T_MAG: begin
        ctrl.op   = tss_pkg::OP_MAG;
        state_nxt = T_LO;
      end
      T_LO: begin
        ctrl.op   = tss_pkg::OP_LO;
        state_nxt = T_HI;
      end
      T_HI: begin
        ctrl.op   = tss_pkg::OP_HI;
        state_nxt = T_SCL;
      end
      T_SCL: begin
        ctrl.op   = tss_pkg::OP_SCL;
        state_nxt = T_ACC;
      end
      T_ACC: begin
        ctrl.op = tss_pkg::OP_ACC;
        if (m_r == '0) begin
          state_nxt = F_MAG;
        end else begin
          m_nxt     = m_r - MW'(1);
          state_nxt = T_MAG;
        end
      end
      F_MAG: begin
        ctrl.op   = tss_pkg::OP_MAG;
        state_nxt = F_RND;
      end
      F_RND: begin
        ctrl.op   = tss_pkg::OP_RND;
        state_nxt = F_STO;
      end
      F_STO: begin
        ctrl.op = tss_pkg::OP_CLEAR;
        if ((ax_r == 2'd2) && (d_r == 2'd2)) begin
          state_nxt = S_DONE;
        end else begin
          ax_nxt = (ax_r == 2'd2) ? 2'd0 : (ax_r + 2'd1);
          d_nxt  = nd;
          if (TERMS > int'(nd)) begin
            m_nxt     = MW'(TERMS - 1 - int'(nd));
            state_nxt = T_MAG;
          end else begin
            // derivative with no terms left reads as zero
            state_nxt = F_MAG;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      d_r         <= 2'd0;
      ax_r        <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      d_r         <= d_nxt;
      ax_r        <= ax_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
    t_r   <= t_nxt;
    m_r   <= m_nxt;
    if (store) begin
      res_r[slot] <= dp_res;
    end
    if (out_load) begin
      out_data_r.pos_x     <= res_r[0];
      out_data_r.pos_y     <= res_r[1];
      out_data_r.pos_z     <= res_r[2];
      out_data_r.vel_x     <= res_r[3];
      out_data_r.vel_y     <= res_r[4];
      out_data_r.vel_z     <= res_r[5];
      out_data_r.acc_x     <= res_r[6];
      out_data_r.acc_y     <= res_r[7];
      out_data_r.acc_z     <= res_r[8];
      out_data_r.saturated <= dp_clip;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && eval_seg_ok) |=> (state_r == S_INIT))
    else $error("accepted evaluate did not start the sequencer");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result presented without a finished evaluation");

  a_term_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_MAG) |-> (termsum < 5'(TERMS)))
    else $error("coefficient read beyond the term count");

endmodule

`default_nettype wire

@@ bench/trajectory_segment_sampler_core_tb.sv @@
// trajectory_segment_sampler_core_tb: self-checking bench for the trajectory segment sampler
// drives coefficient writes and evaluates with random idling, predicts each sample in
// fixed point and compares it field by field; depends on tss_pkg and the core only
`timescale 1ns / 100ps

module trajectory_segment_sampler_core_tb;

  localparam int SEG_COUNT   = 64;
  localparam int TERM_COUNT  = 8;
  localparam int SLOTS       = tss_pkg::AXES * TERM_COUNT;
  localparam int ITEM_TARGET = 1450;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN       = 400;
  localparam int LIMIT       = 3000000;

  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam longint Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint Q_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [47:0] COEF_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] COEF_MIN = 48'sh8000_0000_0000;
  localparam logic signed [47:0] COEF_ONE = 48'sh0001_0000_0000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  tss_pkg::tss_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  tss_pkg::tss_out_t out_data;

  trajectory_segment_sampler_core #(
    .SEGMENTS(SEG_COUNT),
    .TERMS(TERM_COUNT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tss_pkg::tss_in_t  pending_reqs[$];
  tss_pkg::tss_out_t expected_samples[$];
  longint   coef_table[SEG_COUNT][tss_pkg::AXES][TERM_COUNT];
  bit       gen_written[SEG_COUNT][tss_pkg::AXES][TERM_COUNT];
  bit       clipped;
  int       real_items = 0;
  int       pending_total = 0;
  int       requests_taken = 0;
  int       samples_seen = 0;
  int       mismatches = 0;
  int       cycle_count = 0;
  int       tx_wait = 0;
  int       rx_wait = 0;
  int       rx_hold = 0;
  bit       tx_quiet = 1'b0;
  bit       rx_quiet = 1'b0;

  string field_names[10] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                             "acc_x", "acc_y", "acc_z", "saturated"};

  // fixed-point helpers of the sample predictor

  function automatic longint from_mag(input bit neg, input longint unsigned mag);
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF_FFFF_FFFF) begin
        clipped = 1'b1;
        return Q_MAX;
      end
      return longint'(mag);
    end
    if (mag >= 64'h8000_0000_0000_0000) begin
      if (mag > 64'h8000_0000_0000_0000) clipped = 1'b1;
      return Q_MIN;
    end
    return -longint'(mag);
  endfunction

  function automatic longint time_mul(input longint a, input logic [23:0] t);
    bit neg;
    longint unsigned mag, tt, hi, lo;
    neg = (a < 0);
    mag = 64'(a);
    if (neg) mag = 64'd0 - mag;
    tt = 64'(t);
    hi = (mag >> 32) * tt;
    lo = (mag & 64'hFFFF_FFFF) * tt + 64'h8000;
    if (hi >= 64'h0000_8000_0000_0000) begin
      clipped = 1'b1;
      return neg ? Q_MIN : Q_MAX;
    end
    return from_mag(neg, (hi << 16) + (lo >> 16));
  endfunction

  function automatic longint add_sat(input longint a, input longint b);
    if (b > 0 && a > Q_MAX - b) begin
      clipped = 1'b1;
      return Q_MAX;
    end
    if (b < 0 && a < Q_MIN - b) begin
      clipped = 1'b1;
      return Q_MIN;
    end
    return a + b;
  endfunction

  function automatic logic [47:0] to_q16(input longint a);
    bit neg;
    longint unsigned mag, r;
    neg = (a < 0);
    mag = 64'(a);
    if (neg) mag = 64'd0 - mag;
    r = (mag + 64'h8000) >> 16;
    if (!neg) begin
      if (r > 64'h0000_7FFF_FFFF_FFFF) begin
        clipped = 1'b1;
        r = 64'h0000_7FFF_FFFF_FFFF;
      end
      return r[47:0];
    end
    if (r > 64'h0000_8000_0000_0000) begin
      clipped = 1'b1;
      r = 64'h0000_8000_0000_0000;
    end
    r = 64'd0 - r;
    return r[47:0];
  endfunction

  function automatic longint horner_axis(input int seg, input int axis, input int d,
                                         input logic [23:0] t);
    longint acc, w, c;
    int m;
    acc = 0;
    for (m = TERM_COUNT - 1 - d; m >= 0; m--) begin
      w = (d == 0) ? 1 : (d == 1) ? longint'(m + 1) : longint'((m + 2) * (m + 1));
      c = coef_table[seg][axis][m + d] * w;
      acc = add_sat(time_mul(acc, t), c);
    end
    return acc;
  endfunction

  function automatic tss_pkg::tss_out_t sample_trajectory(input int seg,
                                                          input logic [23:0] t);
    logic [47:0] r [9];
    tss_pkg::tss_out_t s;
    int d, a;
    clipped = 1'b0;
    for (d = 0; d < 3; d++)
      for (a = 0; a < tss_pkg::AXES; a++)
        r[d * tss_pkg::AXES + a] = to_q16(horner_axis(seg, a, d, t));
    s.pos_x = r[0];
    s.pos_y = r[1];
    s.pos_z = r[2];
    s.vel_x = r[3];
    s.vel_y = r[4];
    s.vel_z = r[5];
    s.acc_x = r[6];
    s.acc_y = r[7];
    s.acc_z = r[8];
    s.saturated = clipped;
    return s;
  endfunction

  task automatic apply_request(input tss_pkg::tss_in_t r);
    logic [47:0] v;
    if (r.req_type == tss_pkg::REQ_WRITE) begin
      v = r.coefficient_value;
      if (r.axis_index < tss_pkg::AXES)
        coef_table[r.segment_index][r.axis_index][r.term_index] = {{16{v[47]}}, v};
    end else begin
      expected_samples.push_back(sample_trajectory(r.segment_index, r.local_time));
    end
  endtask

  // stimulus generation

  function automatic tss_pkg::tss_in_t mk_write(input logic [5:0] seg, input logic [1:0] axis,
                                                input logic [2:0] term,
                                                input logic [47:0] val);
    tss_pkg::tss_in_t r;
    r.req_type = tss_pkg::REQ_WRITE;
    r.segment_index = seg;
    r.axis_index = axis;
    r.term_index = term;
    r.coefficient_value = val;
    r.local_time = 24'($urandom);
    return r;
  endfunction

  function automatic tss_pkg::tss_in_t mk_eval(input logic [5:0] seg, input logic [23:0] t);
    tss_pkg::tss_in_t r;
    r.req_type = tss_pkg::REQ_EVAL;
    r.segment_index = seg;
    r.axis_index = 2'($urandom);
    r.term_index = 3'($urandom);
    r.coefficient_value = 48'({$urandom, $urandom});
    r.local_time = t;
    return r;
  endfunction

  function automatic logic signed [47:0] rand_coef(input bit gentle);
    logic signed [47:0] v;
    v = 48'({$urandom, $urandom});
    if (gentle) return v >>> $urandom_range(10, 30);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COEF_MAX;
      2:       return COEF_MIN;
      3, 4, 5: return v >>> $urandom_range(8, 40);
      default: return v;
    endcase
  endfunction

  function automatic logic [23:0] rand_time(input bit gentle);
    if (gentle) return 24'($urandom_range(0, 24'h018000));
    case ($urandom_range(0, 9))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'h010000;
      3, 4:    return 24'($urandom_range(0, 24'h01FFFF));
      5, 6:    return 24'($urandom_range(0, 24'h07FFFF));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic bit seg_full(input int seg);
    int a, j;
    for (a = 0; a < tss_pkg::AXES; a++)
      for (j = 0; j < TERM_COUNT; j++)
        if (!gen_written[seg][a][j]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic push_req(input tss_pkg::tss_in_t r);
    pending_reqs.push_back(r);
    if (r.req_type == tss_pkg::REQ_EVAL || r.axis_index < tss_pkg::AXES) real_items++;
    if (r.req_type == tss_pkg::REQ_WRITE && r.axis_index < tss_pkg::AXES)
      gen_written[r.segment_index][r.axis_index][r.term_index] = 1'b1;
  endtask

  task automatic load_segment(input int seg, input bit gentle);
    int slot [SLOTS];
    int i, k, tmp;
    for (i = 0; i < SLOTS; i++) slot[i] = i;
    for (i = SLOTS - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = slot[i];
      slot[i] = slot[k];
      slot[k] = tmp;
    end
    for (i = 0; i < SLOTS; i++) begin
      if ($urandom_range(0, 29) == 0)
        push_req(mk_write(6'(seg), AXIS_NONE, 3'($urandom), rand_coef(1'b0)));
      push_req(mk_write(6'(seg), 2'(slot[i] / TERM_COUNT), 3'(slot[i] % TERM_COUNT),
                        rand_coef(gentle)));
    end
  endtask

  function automatic int draw_gap(input bit quiet);
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // input driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(in_data);
        requests_taken <= requests_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (tx_wait != 0) begin
          tx_wait <= tx_wait - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          tx_wait <= draw_gap(tx_quiet);
          if ($urandom_range(0, 39) == 0) tx_quiet <= !tx_quiet;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with long hold-offs so the core backs up

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= (rx_hold == 1);
    end else if (out_valid && out_ready) begin
      if (samples_seen == 5 || samples_seen == 120) begin
        rx_hold <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        rx_wait <= draw_gap(rx_quiet);
        out_ready <= 1'b0;
        if ($urandom_range(0, 39) == 0) rx_quiet <= !rx_quiet;
      end
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result monitor

  function automatic logic [47:0] out_field(input tss_pkg::tss_out_t o, input int i);
    case (i)
      0:       return o.pos_x;
      1:       return o.pos_y;
      2:       return o.pos_z;
      3:       return o.vel_x;
      4:       return o.vel_y;
      5:       return o.vel_z;
      6:       return o.acc_x;
      7:       return o.acc_y;
      8:       return o.acc_z;
      default: return 48'(o.saturated);
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [47:0] want,
                               input logic [47:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s at cycle %0d: expected %h, got %h", what, cycle_count, want, got);
  endtask

  always @(posedge clk) begin : check_samples
    tss_pkg::tss_out_t want;
    int i;
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        note_mismatch("unexpected transaction", '0, out_data.pos_x);
      end else begin
        want = expected_samples.pop_front();
        for (i = 0; i < 10; i++)
          if (out_field(want, i) !== out_field(out_data, i))
            note_mismatch(field_names[i], out_field(want, i), out_field(out_data, i));
      end
      samples_seen <= samples_seen + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("trajectory_segment_sampler_core test failed");
      $finish;
    end
  end

  initial begin : run_test
    int a, j, seg, n;
    bit gentle;
    logic signed [47:0] v;

    // corners on the last segment: full-scale coefficients of both signs on x and y, plus and minus one on z
    for (a = 0; a < tss_pkg::AXES; a++)
      for (j = 0; j < TERM_COUNT; j++) begin
        case (a)
          0:       v = COEF_MAX;
          1:       v = COEF_MIN;
          default: v = j[0] ? -COEF_ONE : COEF_ONE;
        endcase
        push_req(mk_write(6'd63, 2'(a), 3'(j), v));
      end
    push_req(mk_write(6'd63, AXIS_NONE, 3'd0, 48'({$urandom, $urandom})));
    push_req(mk_eval(6'd63, 24'h000000));
    push_req(mk_eval(6'd63, 24'hFFFFFF));
    push_req(mk_eval(6'd63, 24'h010000));
    push_req(mk_eval(6'd63, 24'h000001));

    while (real_items < ITEM_TARGET) begin
      seg = $urandom_range(0, SEG_COUNT - 1);
      if ($urandom_range(0, 9) < 7) begin
        gentle = ($urandom_range(0, 2) != 0);
        if (!seg_full(seg) || $urandom_range(0, 3) == 0)
          load_segment(seg, gentle);
        else
          repeat ($urandom_range(1, 4))
            push_req(mk_write(6'(seg), 2'($urandom_range(0, tss_pkg::AXES - 1)),
                              3'($urandom), rand_coef(gentle)));
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 15) == 0)
            push_req(mk_write(6'(seg), AXIS_NONE, 3'($urandom), rand_coef(1'b0)));
          push_req(mk_eval(6'(seg), rand_time(gentle)));
        end
      end else begin
        case ($urandom_range(0, 2))
          0: push_req(mk_write(6'(seg), 2'($urandom), 3'($urandom), rand_coef(1'b0)));
          1: begin
            if (seg_full(seg))
              push_req(mk_eval(6'(seg), rand_time(1'b0)));
            else
              push_req(mk_write(6'(seg), 2'($urandom_range(0, tss_pkg::AXES - 1)),
                                3'($urandom), rand_coef(1'b0)));
          end
          default: push_req(mk_write(6'(seg), AXIS_NONE, 3'($urandom), rand_coef(1'b0)));
        endcase
      end
    end
    pending_total = pending_reqs.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_taken < pending_total) @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (mismatches == 0)
      $display("trajectory_segment_sampler_core test passed");
    else
      $display("trajectory_segment_sampler_core test failed");
    $finish;
  end

endmodule
